// ===== sv/rms_row_normalizer_macros.svh =====
// Assertion macros shared by the normalizer RTL.
`ifndef RMS_ROW_NORMALIZER_MACROS_SVH
`define RMS_ROW_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RMSN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RMSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rmsn_pkg.sv =====
// Shared types and constants of the RMS row normalizer.
package rmsn_pkg;

  localparam int DATA_W = 16;
  localparam int INV_W  = 33;
  localparam int MEAN_W = 31;
  localparam int CFG_AW = 3;

  localparam logic [1:0] ACT_GAIN = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  localparam logic       REG_EPSILON = 1'b0;
  localparam logic [31:0] EPS_RESET  = 32'd1;

  typedef struct packed {
    logic                     done;
    logic                     clip;
    logic signed [DATA_W-1:0] y;
  } mul_res_t;

  typedef struct packed {
    logic             done;
    logic [INV_W-1:0] inv;
  } inv_res_t;

endpackage

// ===== sv/rmsn_in_if.sv =====
// Input channel: action, gain index, value and row end.
interface rmsn_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [11:0]                       gain_index;
  logic signed [rmsn_pkg::DATA_W-1:0] value;
  logic                              row_end;

  modport source (output valid, action, gain_index, value, row_end, input ready);
  modport sink   (input valid, action, gain_index, value, row_end, output ready);
endinterface

// ===== sv/rmsn_out_if.sv =====
// Result channel: normalized sample with flags and status.
interface rmsn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmsn_pkg::DATA_W-1:0] normalized;
  logic                              last_of_row;
  logic                              clipped;
  logic [1:0]                        status;

  modport source (output valid, normalized, last_of_row, clipped, status, input ready);
  modport sink   (input valid, normalized, last_of_row, clipped, status, output ready);
endinterface

// ===== sv/rmsn_invrms.sv =====
// Serial row-end unit: mean divide, reciprocal divide and integer square root.
module rmsn_invrms #(
  parameter int CW = 13,
  parameter int SW = 43
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SW-1:0]              sum,
  input  logic [CW-1:0]              cnt,
  input  logic [31:0]                eps,
  output rmsn_pkg::inv_res_t         res
);

  localparam int KW = $clog2((SW > 65) ? SW + 1 : 66);
  localparam int DW = rmsn_pkg::MEAN_W + 2;  // mean + epsilon

  typedef enum logic [2:0] {S_IDLE, S_MEAN, S_ADD, S_RECIP, S_ROOT} st_t;

  st_t              st_r;
  logic [KW-1:0]    k_r;
  logic [SW-1:0]    dsr_r;
  logic [CW-1:0]    div_r;
  logic [CW:0]      mrem_r;
  logic [DW-1:0]    d_r;
  logic [DW:0]      rrem_r;
  logic [63:0]      q_r;
  logic [35:0]      srem_r;
  logic [31:0]      root_r;
  logic             done_r;
  logic [rmsn_pkg::INV_W-1:0] inv_r;

  logic [CW:0]   msh;
  logic          mge;
  logic [DW:0]   rsh;
  logic          rge;
  logic [35:0]   ssh;
  logic [35:0]   trial;
  logic          sge;
  logic [DW-1:0] dsum;

  always_comb begin
    msh   = {mrem_r[CW-1:0], dsr_r[SW-1]};
    mge   = msh >= {1'b0, div_r};
    rsh   = {rrem_r[DW-1:0], (k_r == '0)};
    rge   = rsh >= {1'b0, d_r};
    ssh   = {srem_r[33:0], q_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    sge   = ssh >= trial;
    dsum  = DW'(dsr_r[rmsn_pkg::MEAN_W-1:0]) + DW'(eps);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            dsr_r  <= sum;
            div_r  <= (cnt == '0) ? CW'(1) : cnt;
            mrem_r <= '0;
            k_r    <= '0;
            done_r <= 1'b0;
            st_r   <= S_MEAN;
          end
        end
        S_MEAN: begin
          mrem_r <= mge ? (msh - {1'b0, div_r}) : msh;
          dsr_r  <= {dsr_r[SW-2:0], mge};
          if (k_r == KW'(SW - 1)) begin
            st_r <= S_ADD;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_ADD: begin
          k_r    <= '0;
          rrem_r <= '0;
          q_r    <= '0;
          // mean + eps of zero counts as one; one maps straight to 2^32
          if (dsum <= DW'(1)) begin
            inv_r  <= rmsn_pkg::INV_W'(64'h1_0000_0000);
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end else begin
            d_r  <= dsum;
            st_r <= S_RECIP;
          end
        end
        S_RECIP: begin
          rrem_r <= rge ? (rsh - {1'b0, d_r}) : rsh;
          q_r    <= {q_r[62:0], rge};
          if (k_r == KW'(64)) begin
            k_r    <= '0;
            srem_r <= '0;
            root_r <= '0;
            st_r   <= S_ROOT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_ROOT: begin
          srem_r <= sge ? (ssh - trial) : ssh;
          root_r <= {root_r[30:0], sge};
          q_r    <= {q_r[61:0], 2'b00};
          if (k_r == KW'(31)) begin
            inv_r  <= {1'b0, root_r[30:0], sge};
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.inv  = inv_r;

endmodule

// ===== sv/rmsn_smul.sv =====
// Digit-serial multiply of sample, gain and inverse RMS, radix 16, with rounding.
module rmsn_smul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rmsn_pkg::DATA_W-1:0] x,
  input  logic signed [rmsn_pkg::DATA_W-1:0] g,
  input  logic [rmsn_pkg::INV_W-1:0]         inv,
  output rmsn_pkg::mul_res_t                 res
);

  typedef enum logic [1:0] {M_IDLE, M_XG, M_STEP, M_FIN} st_t;

  st_t                 st_r;
  logic [3:0]          k_r;
  logic signed [31:0]  xg_r;
  logic [35:0]         dig_r;
  logic signed [37:0]  acc_r;
  logic [35:0]         lo_r;
  logic                done_r;
  logic                clip_r;
  logic signed [rmsn_pkg::DATA_W-1:0] y_r;

  logic signed [36:0] prod;
  logic signed [37:0] psum;
  logic signed [37:0] yw;

  always_comb begin
    prod = 37'(xg_r) * 37'($signed({1'b0, dig_r[3:0]}));
    psum = acc_r + 38'(prod);
    // floor((p + 2^35) / 2^36): high part plus the bit just below it
    yw   = acc_r + $signed({37'd0, lo_r[35]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            done_r <= 1'b0;
            st_r   <= M_XG;
          end
        end
        M_XG: begin
          xg_r  <= 32'(x) * 32'(g);
          dig_r <= 36'(inv);
          acc_r <= '0;
          lo_r  <= '0;
          k_r   <= '0;
          st_r  <= M_STEP;
        end
        M_STEP: begin
          lo_r  <= {psum[3:0], lo_r[35:4]};
          acc_r <= psum >>> 4;
          dig_r <= {4'd0, dig_r[35:4]};
          if (k_r == 4'd8) begin
            st_r <= M_FIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        M_FIN: begin
          if (yw > 38'sd32767) begin
            y_r    <= 16'sh7fff;
            clip_r <= 1'b1;
          end else if (yw < -38'sd32768) begin
            y_r    <= -16'sh8000;
            clip_r <= 1'b1;
          end else begin
            y_r    <= yw[15:0];
            clip_r <= 1'b0;
          end
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.clip = clip_r;
  assign res.y    = y_r;

endmodule

// ===== sv/rms_row_normalizer.sv =====
// RMS row normalizer: gain writes and sample pushes are taken one item per cycle while
// the input is ready. Row end: the serial divide/root unit computes the inverse RMS
// before reads are taken; input stalls meanwhile.
// A read result passes the read state, the radix-16 multiplier and the done state
// before it is registered; input stalls meanwhile. An empty read goes straight to done.
// Synchronous active-low reset clears control state; stores are undefined until written.
`include "rms_row_normalizer_macros.svh"

module rms_row_normalizer #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rmsn_in_if.sink                       in_ch,
  rmsn_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rmsn_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SW = 30 + CW;
  localparam int DW = rmsn_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_FILL, ST_SUMW, ST_CALC, ST_READY, ST_RD, ST_MUL, ST_DONE
  } st_t;

  st_t st_r;
  st_t ret_r;

  logic signed [DW-1:0] sample_mem [MAX_DIM];
  logic signed [DW-1:0] gain_mem   [MAX_DIM];

  logic [31:0]          eps_r;
  logic [SW-1:0]        sum_r;
  logic [31:0]          sq_r;
  logic                 sq_v_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        rp_r;
  logic                 ovf_r;
  logic [rmsn_pkg::INV_W-1:0] inv_r;
  logic                 start_r;
  logic signed [DW-1:0] x_q;
  logic signed [DW-1:0] g_q;
  logic                 last_p_r;
  logic [1:0]           stat_p_r;

  logic                 out_v_r;
  logic signed [DW-1:0] out_y_r;
  logic                 out_last_r;
  logic                 out_clip_r;
  logic [1:0]           out_stat_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 cfg_wr;
  logic                 gain_ok;
  logic                 rp_last;
  rmsn_pkg::inv_res_t   inv_res;
  rmsn_pkg::mul_res_t   mul_res;

  assign in_ch.ready = (st_r == ST_FILL) || (st_r == ST_READY);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = (cfg_paddr[2] == rmsn_pkg::REG_EPSILON) ? eps_r : 32'd0;
  assign gain_ok     = 32'(in_ch.gain_index) < 32'(MAX_DIM);
  assign rp_last     = (CW'(rp_r + 1'b1) >= cnt_r) || (rp_r == {CW{1'b1}});

  assign out_ch.valid       = out_v_r;
  assign out_ch.normalized  = out_y_r;
  assign out_ch.last_of_row = out_last_r;
  assign out_ch.clipped     = out_clip_r;
  assign out_ch.status      = out_stat_r;

  rmsn_invrms #(.CW(CW), .SW(SW)) u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .sum   (sum_r),
    .cnt   (cnt_r),
    .eps   (eps_r),
    .res   (inv_res)
  );

  rmsn_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_RD),
    .x     (x_q),
    .g     (g_q),
    .inv   (inv_r),
    .res   (mul_res)
  );

  // stores: one write port, read registered at the read pointer
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == rmsn_pkg::ACT_GAIN && gain_ok) begin
      gain_mem[AW'(in_ch.gain_index)] <= in_ch.value;
    end
    if (in_acc && in_ch.action == rmsn_pkg::ACT_PUSH && st_r == ST_FILL &&
        cnt_r < CW'(MAX_DIM)) begin
      sample_mem[cnt_r[AW-1:0]] <= in_ch.value;
    end
    if (in_acc && in_ch.action == rmsn_pkg::ACT_READ) begin
      x_q <= sample_mem[rp_r[AW-1:0]];
      g_q <= gain_mem[rp_r[AW-1:0]];
    end
    sq_r <= 32'(in_ch.value) * 32'(in_ch.value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rmsn_pkg::EPS_RESET;
    end else if (cfg_wr && cfg_pready && cfg_paddr[2] == rmsn_pkg::REG_EPSILON) begin
      eps_r <= cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_FILL;
      ret_r      <= ST_FILL;
      sum_r      <= '0;
      sq_v_r     <= 1'b0;
      cnt_r      <= '0;
      rp_r       <= '0;
      ovf_r      <= 1'b0;
      inv_r      <= '0;
      start_r    <= 1'b0;
      out_v_r    <= 1'b0;
      last_p_r   <= 1'b0;
      stat_p_r   <= rmsn_pkg::STAT_OK;
    end else begin
      sq_v_r  <= in_acc && in_ch.action == rmsn_pkg::ACT_PUSH && st_r == ST_FILL &&
                 cnt_r < CW'(MAX_DIM);
      start_r <= (st_r == ST_SUMW);
      if (sq_v_r) begin
        sum_r <= sum_r + SW'(sq_r);
      end
      if (out_v_r && out_ch.ready && st_r != ST_DONE) begin
        out_v_r <= 1'b0;
      end
      unique case (st_r)
        ST_FILL, ST_READY: begin
          if (in_acc) begin
            priority if (in_ch.action == rmsn_pkg::ACT_PUSH && st_r == ST_FILL) begin
              if (cnt_r < CW'(MAX_DIM)) begin
                cnt_r  <= cnt_r + 1'b1;
              end else begin
                ovf_r <= 1'b1;
              end
              if (in_ch.row_end) begin
                st_r <= ST_SUMW;
              end
            end else if (in_ch.action == rmsn_pkg::ACT_READ) begin
              if (st_r == ST_READY && rp_r < cnt_r) begin
                last_p_r <= rp_last;
                stat_p_r <= ovf_r ? rmsn_pkg::STAT_OVF : rmsn_pkg::STAT_OK;
                if (rp_last) begin
                  sum_r <= '0;
                  cnt_r <= '0;
                  rp_r  <= '0;
                  ovf_r <= 1'b0;
                  ret_r <= ST_FILL;
                end else begin
                  rp_r  <= rp_r + 1'b1;
                  ret_r <= ST_READY;
                end
                st_r <= ST_RD;
              end else begin
                last_p_r <= 1'b0;
                stat_p_r <= rmsn_pkg::STAT_EMPTY;
                ret_r    <= st_r;
                st_r     <= ST_DONE;
              end
            end else begin
            end
          end
        end
        ST_SUMW: begin
          st_r    <= ST_CALC;
        end
        ST_CALC: begin
          if (!start_r && inv_res.done) begin
            inv_r <= inv_res.inv;
            rp_r  <= '0;
            st_r  <= ST_READY;
          end
        end
        ST_RD: begin
          st_r <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_res.done) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_v_r    <= 1'b1;
            out_last_r <= last_p_r;
            out_stat_r <= stat_p_r;
            if (stat_p_r == rmsn_pkg::STAT_EMPTY) begin
              out_y_r    <= '0;
              out_clip_r <= 1'b0;
            end else begin
              out_y_r    <= mul_res.y;
              out_clip_r <= mul_res.clip;
            end
            st_r <= ret_r;
          end
        end
        default: st_r <= ST_FILL;
      endcase
    end
  end

  `RMSN_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_DIM), "sample count beyond store")
  `RMSN_ASSERT_NOW(a_rp_in_row, st_r == ST_READY, rp_r < cnt_r, "read pointer past row")
  `RMSN_ASSERT_NEXT(a_row_end_start, st_r == ST_SUMW, start_r && st_r == ST_CALC,
                    "row-end unit not started")
  `RMSN_ASSERT_NOW(a_no_overwrite, st_r == ST_DONE && out_free, 1'b1 && !(out_v_r && !out_ch.ready),
                   "result register overwritten")

endmodule
